FILE: rtl/soag_pkg.sv
// Shared types and constants of the spiral order address generator.
// Used by the register block, the walker and the top level; depends on nothing.
package soag_pkg;

  localparam int CNT_W  = 5;   // width of the row and column count registers
  localparam int MODE_W = 2;
  localparam int IDX_W  = 4;   // width of the emitted row and column indices
  localparam int NUM_W  = 9;   // width of the emitted cell number
  localparam int ADDR_W = 4;
  localparam int DATA_W = 32;

  // Walk selection.
  localparam logic [MODE_W-1:0] MODE_CW_UP    = 2'd0;
  localparam logic [MODE_W-1:0] MODE_CCW_UP   = 2'd1;
  localparam logic [MODE_W-1:0] MODE_CCW_DOWN = 2'd2;
  localparam logic [MODE_W-1:0] MODE_CW_DOWN  = 2'd3;

  // Register index, taken from paddr[3:2].
  localparam logic [1:0] REG_ROW_COUNT    = 2'd0;
  localparam logic [1:0] REG_COLUMN_COUNT = 2'd1;
  localparam logic [1:0] REG_WALK_MODE    = 2'd2;

  typedef struct packed {
    logic [CNT_W-1:0]  row_count;
    logic [CNT_W-1:0]  column_count;
    logic [MODE_W-1:0] walk_mode;
  } cfg_t;

  typedef struct packed {
    logic [IDX_W-1:0] row_index;
    logic [IDX_W-1:0] col_index;
    logic [NUM_W-1:0] cell_number;
    logic             last_cell;
    logic             idle;
  } res_t;

endpackage

FILE: rtl/soag_cfg_regs.sv
// Configuration registers of the spiral order address generator, behind an APB-style port.
// Depends on soag_pkg for the register layout and the index codes.
module soag_cfg_regs import soag_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg
);

  logic [1:0] reg_index;
  logic       wr_en;

  assign reg_index = paddr[ADDR_W-1:2];
  assign wr_en     = psel && penable && pwrite;
  assign pready    = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.row_count    <= CNT_W'(1);
      cfg.column_count <= CNT_W'(1);
      cfg.walk_mode    <= MODE_CW_UP;
    end else if (wr_en) begin
      unique case (reg_index)
        REG_ROW_COUNT:    cfg.row_count    <= pwdata[CNT_W-1:0];
        REG_COLUMN_COUNT: cfg.column_count <= pwdata[CNT_W-1:0];
        REG_WALK_MODE:    cfg.walk_mode    <= pwdata[MODE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_index)
      REG_ROW_COUNT:    prdata = DATA_W'(cfg.row_count);
      REG_COLUMN_COUNT: prdata = DATA_W'(cfg.column_count);
      REG_WALK_MODE:    prdata = DATA_W'(cfg.walk_mode);
      default:          prdata = '0;
    endcase
  end

endmodule

FILE: rtl/soag_walker.sv
// Walk state of the spiral order address generator: bounds, side, position and number,
// with the logic that emits one cell and steps to the next. Depends on soag_pkg.
module soag_walker import soag_pkg::*; #(
  parameter int MAX_SIDE = 16
) (
  input  logic clk,
  input  logic rst,
  input  logic step,
  input  logic restart,
  input  cfg_t cfg,
  output res_t res
);

  localparam int SW = $clog2(MAX_SIDE + 1);
  localparam int BW = SW + 1;
  localparam int PW = (2 * SW > NUM_W) ? 2 * SW : NUM_W;

  localparam logic [1:0] SIDE_FIRST  = 2'd0;
  localparam logic [1:0] SIDE_SECOND = 2'd1;
  localparam logic [1:0] SIDE_THIRD  = 2'd2;
  localparam logic [1:0] SIDE_FOURTH = 2'd3;

  typedef logic signed [BW-1:0] crd_t;

  typedef struct packed {
    crd_t       top;
    crd_t       bottom;
    crd_t       left;
    crd_t       right;
    logic [1:0] side;
    crd_t       pos;
  } walk_t;

  localparam crd_t ONE  = crd_t'(1);
  localparam crd_t ZERO = crd_t'(0);

  walk_t            walk, walk_next, base, adv;
  logic             ccw, ccw_next, down, down_next;
  logic [NUM_W-1:0] number, number_next, base_num;
  logic             active, active_next, base_act;
  logic [SW-1:0]    rows_c, cols_c;
  logic [PW-1:0]    area;
  crd_t             cell_r, cell_c;
  logic [1:0]       nxt;
  logic             found, ended;

  function automatic logic [SW-1:0] clamp_size(logic [CNT_W-1:0] v);
    if (v == '0) return SW'(1);
    if (32'(v) > MAX_SIDE) return SW'(MAX_SIDE);
    return SW'(v);
  endfunction

  function automatic logic side_up(logic [1:0] s);
    return (s == SIDE_FIRST) || (s == SIDE_SECOND);
  endfunction

  function automatic crd_t side_first(walk_t w, logic ccw_f, logic [1:0] s);
    if (!ccw_f) begin
      case (s)
        SIDE_FIRST:  return w.left;
        SIDE_SECOND: return w.top;
        SIDE_THIRD:  return w.right;
        default:     return w.bottom;
      endcase
    end
    case (s)
      SIDE_FIRST:  return w.top;
      SIDE_SECOND: return w.left;
      SIDE_THIRD:  return w.bottom;
      default:     return w.right;
    endcase
  endfunction

  function automatic crd_t side_last(walk_t w, logic ccw_f, logic [1:0] s);
    if (!ccw_f) begin
      case (s)
        SIDE_FIRST:  return w.right;
        SIDE_SECOND: return w.bottom;
        SIDE_THIRD:  return w.left;
        default:     return w.top;
      endcase
    end
    case (s)
      SIDE_FIRST:  return w.bottom;
      SIDE_SECOND: return w.right;
      SIDE_THIRD:  return w.top;
      default:     return w.left;
    endcase
  endfunction

  function automatic logic in_side(walk_t w, logic ccw_f, logic [1:0] s, crd_t p);
    crd_t l;
    l = side_last(w, ccw_f, s);
    return side_up(s) ? (p <= l) : (p >= l);
  endfunction

  // The inner two sides of a lap are only walked while the grid has not collapsed.
  function automatic logic side_guard(walk_t w, logic ccw_f, logic [1:0] s);
    logic rows_ok, cols_ok;
    rows_ok = w.top <= w.bottom;
    cols_ok = w.left <= w.right;
    if (s == SIDE_THIRD)  return ccw_f ? cols_ok : rows_ok;
    if (s == SIDE_FOURTH) return ccw_f ? rows_ok : cols_ok;
    return 1'b1;
  endfunction

  function automatic walk_t side_shrink(walk_t w, logic ccw_f, logic [1:0] s);
    walk_t r;
    r = w;
    if (!ccw_f) begin
      case (s)
        SIDE_FIRST:  r.top    = w.top + ONE;
        SIDE_SECOND: r.right  = w.right - ONE;
        SIDE_THIRD:  r.bottom = w.bottom - ONE;
        default:     r.left   = w.left + ONE;
      endcase
    end else begin
      case (s)
        SIDE_FIRST:  r.left   = w.left + ONE;
        SIDE_SECOND: r.bottom = w.bottom - ONE;
        SIDE_THIRD:  r.right  = w.right - ONE;
        default:     r.top    = w.top + ONE;
      endcase
    end
    return r;
  endfunction

  assign rows_c = clamp_size(cfg.row_count);
  assign cols_c = clamp_size(cfg.column_count);
  assign area   = PW'(rows_c) * PW'(cols_c);

  always_comb begin
    base      = walk;
    ccw_next  = ccw;
    down_next = down;
    base_num  = number;
    base_act  = active;
    if (restart) begin
      ccw_next    = (cfg.walk_mode == MODE_CCW_UP) || (cfg.walk_mode == MODE_CCW_DOWN);
      down_next   = (cfg.walk_mode == MODE_CCW_DOWN) || (cfg.walk_mode == MODE_CW_DOWN);
      base.top    = ZERO;
      base.bottom = crd_t'({1'b0, rows_c}) - ONE;
      base.left   = ZERO;
      base.right  = crd_t'({1'b0, cols_c}) - ONE;
      base.side   = SIDE_FIRST;
      base.pos    = side_first(base, ccw_next, SIDE_FIRST);
      base_num    = down_next ? area[NUM_W-1:0] : NUM_W'(1);
      base_act    = 1'b1;
    end

    cell_r = ZERO;
    cell_c = ZERO;
    if (!ccw_next) begin
      case (base.side)
        SIDE_FIRST:  begin cell_r = base.top;    cell_c = base.pos;   end
        SIDE_SECOND: begin cell_r = base.pos;    cell_c = base.right; end
        SIDE_THIRD:  begin cell_r = base.bottom; cell_c = base.pos;   end
        default:     begin cell_r = base.pos;    cell_c = base.left;  end
      endcase
    end else begin
      case (base.side)
        SIDE_FIRST:  begin cell_r = base.pos;    cell_c = base.left;  end
        SIDE_SECOND: begin cell_r = base.bottom; cell_c = base.pos;   end
        SIDE_THIRD:  begin cell_r = base.pos;    cell_c = base.right; end
        default:     begin cell_r = base.top;    cell_c = base.pos;   end
      endcase
    end

    // Step along the side; when it runs out, shrink and turn. At most four turns
    // reach a fresh lap, whose first side is never empty.
    adv     = base;
    adv.pos = side_up(base.side) ? base.pos + ONE : base.pos - ONE;
    found   = in_side(adv, ccw_next, adv.side, adv.pos);
    ended   = 1'b0;
    nxt     = adv.side;
    for (int i = 0; i < 4; i++) begin
      if (!found && !ended) begin
        adv = side_shrink(adv, ccw_next, adv.side);
        nxt = adv.side + 2'd1;
        if (nxt == SIDE_FIRST && !(adv.top <= adv.bottom && adv.left <= adv.right)) begin
          ended = 1'b1;
        end else begin
          adv.side = nxt;
          adv.pos  = side_first(adv, ccw_next, nxt);
          found    = side_guard(adv, ccw_next, nxt) && in_side(adv, ccw_next, nxt, adv.pos);
        end
      end
    end

    if (base_act) begin
      walk_next       = adv;
      number_next     = down_next ? base_num - NUM_W'(1) : base_num + NUM_W'(1);
      active_next     = !ended;
      res.row_index   = IDX_W'($unsigned(cell_r));
      res.col_index   = IDX_W'($unsigned(cell_c));
      res.cell_number = base_num;
      res.last_cell   = ended;
      res.idle        = 1'b0;
    end else begin
      walk_next       = base;
      number_next     = base_num;
      active_next     = 1'b0;
      res.row_index   = '0;
      res.col_index   = '0;
      res.cell_number = '0;
      res.last_cell   = 1'b0;
      res.idle        = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      walk   <= '0;
      ccw    <= 1'b0;
      down   <= 1'b0;
      number <= '0;
      active <= 1'b0;
    end else if (step) begin
      walk   <= walk_next;
      ccw    <= ccw_next;
      down   <= down_next;
      number <= number_next;
      active <= active_next;
    end
  end

`ifndef SYNTHESIS
  a_last_ends_walk: assert property (@(posedge clk) disable iff (rst)
    step && !res.idle && res.last_cell |=> !active)
    else $error("walk still active after its final cell");

  a_walk_continues: assert property (@(posedge clk) disable iff (rst)
    step && !res.idle && !res.last_cell |=> active)
    else $error("walk dropped before its final cell");

  a_restart_emits: assert property (@(posedge clk) disable iff (rst)
    step && restart |-> !res.idle)
    else $error("restart request produced an idle result");
`endif

endmodule

FILE: rtl/spiral_order_address_generator_top.sv
// Top level of the spiral order address generator: request and result registers
// around the walker, plus the configuration registers. Depends on soag_pkg.
//
// Usage: set row_count, column_count and walk_mode over the APB-style port while the
// block is idle, then send requests on the input channel (in_valid, in_ready, restart).
// A request with restart high starts a new walk and yields its first cell; a request
// with restart low yields the next cell. Every request yields exactly one result on
// the output channel (out_valid, out_ready); with no walk active the result has idle
// high and all other fields zero, and last_cell marks the final cell of a walk.
// A taken request waits in the request register, then goes through the walker into the
// result register. Throughput is one request per cycle while results are taken,
// as the walker step is combinational. When the receiver stalls, the result register holds
// and one further request is still taken into the request register; in_ready then falls
// until the result is taken. Reset empties both registers, ends any walk and sets the
// registers to one row, one column and the clockwise ascending walk.
module spiral_order_address_generator_top import soag_pkg::*; #(
  parameter int MAX_SIDE = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              restart,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [IDX_W-1:0]  row_index,
  output logic [IDX_W-1:0]  col_index,
  output logic [NUM_W-1:0]  cell_number,
  output logic              last_cell,
  output logic              idle,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  cfg_t cfg;
  res_t walk_res, res_q;
  logic req_valid, req_restart;
  logic move;

  // A held request goes through the walker whenever the result register can take it.
  assign move     = req_valid && (!out_valid || out_ready);
  assign in_ready = !req_valid || move;

  soag_cfg_regs u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  soag_walker #(
    .MAX_SIDE (MAX_SIDE)
  ) u_walker (
    .clk     (clk),
    .rst     (rst),
    .step    (move),
    .restart (req_restart),
    .cfg     (cfg),
    .res     (walk_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      req_valid <= 1'b1;
    end else if (move) begin
      req_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      req_restart <= restart;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (move) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (move) begin
      res_q <= walk_res;
    end
  end

  assign row_index   = res_q.row_index;
  assign col_index   = res_q.col_index;
  assign cell_number = res_q.cell_number;
  assign last_cell   = res_q.last_cell;
  assign idle        = res_q.idle;

`ifndef SYNTHESIS
  a_idle_result_clear: assert property (@(posedge clk) disable iff (rst)
    out_valid && idle |-> row_index == '0 && col_index == '0 && cell_number == '0
      && !last_cell)
    else $error("idle result carries a cell");

  a_request_held: assert property (@(posedge clk) disable iff (rst)
    req_valid && !move |=> req_valid && $stable(req_restart))
    else $error("held request lost while the result register was full");
`endif

endmodule

FILE: verif/spiral_order_address_generator_top_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for spiral_order_address_generator_top.
// Holds its own model of the spiral walk and depends only on soag_pkg and the RTL.
module spiral_order_address_generator_top_tb;
  import soag_pkg::*;

  localparam int GRID_MAX      = 16;
  localparam int CYCLE_LIMIT   = 200000;
  localparam int RANDOM_ITEMS  = 500;

  logic              clk = 1'b0;
  logic              rst;
  logic              in_valid;
  logic              in_ready;
  logic              restart;
  logic              out_valid;
  logic              out_ready;
  logic [IDX_W-1:0]  row_index;
  logic [IDX_W-1:0]  col_index;
  logic [NUM_W-1:0]  cell_number;
  logic              last_cell;
  logic              idle;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  // Shadow copy of the configuration registers.
  logic [CNT_W-1:0]  grid_rows;
  logic [CNT_W-1:0]  grid_cols;
  logic [MODE_W-1:0] grid_mode;

  // Model state of the walk.
  int               top_b, bot_b, left_b, right_b;
  logic [1:0]       lane;
  int               lane_pos;
  logic [NUM_W-1:0] next_number;
  bit               walking;
  bit               walk_ccw;
  bit               walk_down;

  res_t cells_due[$];
  int   mismatch_count = 0;
  int   cycle_count = 0;
  int   requests_sent = 0;
  bit   idling_on = 1'b1;

  spiral_order_address_generator_top #(.MAX_SIDE(GRID_MAX)) DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .restart(restart),
    .out_valid(out_valid), .out_ready(out_ready),
    .row_index(row_index), .col_index(col_index), .cell_number(cell_number),
    .last_cell(last_cell), .idle(idle),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  function automatic int clamp_side(input logic [CNT_W-1:0] v);
    if (v == '0) return 1;
    if (v > GRID_MAX) return GRID_MAX;
    return int'(v);
  endfunction

  function automatic int lane_first(input logic [1:0] s);
    if (!walk_ccw) begin
      case (s)
        2'd0: return left_b;
        2'd1: return top_b;
        2'd2: return right_b;
        default: return bot_b;
      endcase
    end
    case (s)
      2'd0: return top_b;
      2'd1: return left_b;
      2'd2: return bot_b;
      default: return right_b;
    endcase
  endfunction

  function automatic int lane_last(input logic [1:0] s);
    if (!walk_ccw) begin
      case (s)
        2'd0: return right_b;
        2'd1: return bot_b;
        2'd2: return left_b;
        default: return top_b;
      endcase
    end
    case (s)
      2'd0: return bot_b;
      2'd1: return right_b;
      2'd2: return top_b;
      default: return left_b;
    endcase
  endfunction

  // The inner sides of a lap are walked only while the opposite bounds have not crossed.
  function automatic bit lane_guard(input logic [1:0] s);
    bit rows_ok;
    bit cols_ok;
    rows_ok = top_b <= bot_b;
    cols_ok = left_b <= right_b;
    if (s == 2'd2) return walk_ccw ? cols_ok : rows_ok;
    if (s == 2'd3) return walk_ccw ? rows_ok : cols_ok;
    return 1'b1;
  endfunction

  function automatic void lane_shrink(input logic [1:0] s);
    if (!walk_ccw) begin
      case (s)
        2'd0: top_b++;
        2'd1: right_b--;
        2'd2: bot_b--;
        default: left_b++;
      endcase
    end else begin
      case (s)
        2'd0: left_b++;
        2'd1: bot_b--;
        2'd2: right_b--;
        default: top_b++;
      endcase
    end
  endfunction

  function automatic bit on_lane(input logic [1:0] s, input int p);
    return (s < 2'd2) ? (p <= lane_last(s)) : (p >= lane_last(s));
  endfunction

  // Moves to the following cell; returns 0 when the walk has none left.
  function automatic bit walk_advance();
    logic [1:0] s;
    lane_pos += (lane < 2'd2) ? 1 : -1;
    if (on_lane(lane, lane_pos)) return 1'b1;
    while (1) begin
      lane_shrink(lane);
      s = lane + 2'd1;
      if (s == 2'd0 && !(top_b <= bot_b && left_b <= right_b)) return 1'b0;
      lane = s;
      lane_pos = lane_first(s);
      if (lane_guard(s) && on_lane(s, lane_pos)) return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic res_t spiral_next_cell(input logic rs);
    res_t             due;
    int               nr, nc, r, c;
    logic [NUM_W-1:0] total;
    if (rs) begin
      nr = clamp_side(grid_rows);
      nc = clamp_side(grid_cols);
      walk_ccw  = (grid_mode == MODE_CCW_UP) || (grid_mode == MODE_CCW_DOWN);
      walk_down = (grid_mode == MODE_CCW_DOWN) || (grid_mode == MODE_CW_DOWN);
      top_b = 0;
      bot_b = nr - 1;
      left_b = 0;
      right_b = nc - 1;
      lane = 2'd0;
      lane_pos = lane_first(2'd0);
      total = NUM_W'(nr * nc);
      next_number = walk_down ? total : 9'd1;
      walking = 1'b1;
    end
    due = '0;
    if (!walking) begin
      due.idle = 1'b1;
      return due;
    end
    if (!walk_ccw) begin
      case (lane)
        2'd0: begin r = top_b; c = lane_pos; end
        2'd1: begin r = lane_pos; c = right_b; end
        2'd2: begin r = bot_b; c = lane_pos; end
        default: begin r = lane_pos; c = left_b; end
      endcase
    end else begin
      case (lane)
        2'd0: begin r = lane_pos; c = left_b; end
        2'd1: begin r = bot_b; c = lane_pos; end
        2'd2: begin r = lane_pos; c = right_b; end
        default: begin r = top_b; c = lane_pos; end
      endcase
    end
    due.row_index   = r[IDX_W-1:0];
    due.col_index   = c[IDX_W-1:0];
    due.cell_number = next_number;
    next_number = walk_down ? next_number - 9'd1 : next_number + 9'd1;
    if (!walk_advance()) begin
      due.last_cell = 1'b1;
      walking = 1'b0;
    end
    return due;
  endfunction

  // Result checker.
  always @(posedge clk) begin
    res_t want;
    if (!rst && out_valid && out_ready) begin
      if (cells_due.size() == 0) begin
        $error("unexpected result: row_index %0d col_index %0d cell_number %0d",
               row_index, col_index, cell_number);
        mismatch_count++;
      end else begin
        want = cells_due.pop_front();
        if (row_index !== want.row_index) begin
          $error("row_index: expected %0d, got %0d", want.row_index, row_index);
          mismatch_count++;
        end
        if (col_index !== want.col_index) begin
          $error("col_index: expected %0d, got %0d", want.col_index, col_index);
          mismatch_count++;
        end
        if (cell_number !== want.cell_number) begin
          $error("cell_number: expected %0d, got %0d", want.cell_number, cell_number);
          mismatch_count++;
        end
        if (last_cell !== want.last_cell) begin
          $error("last_cell: expected %0d, got %0d", want.last_cell, last_cell);
          mismatch_count++;
        end
        if (idle !== want.idle) begin
          $error("idle: expected %0d, got %0d", want.idle, idle);
          mismatch_count++;
        end
      end
    end
  end

  // Receiver: while idling_on is set, may drop out_ready for a random stall before each result.
  initial begin
    int stall;
    out_ready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      stall = idling_on ? $urandom_range(0, 3) : 0;
      if (stall > 0) begin
        @(negedge clk) out_ready <= 1'b0;
        repeat (stall - 1) @(negedge clk);
      end
      @(negedge clk) out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  task automatic send_request(input logic rs);
    int gap;
    gap = idling_on ? $urandom_range(0, 3) : 0;
    if (gap > 0) begin
      @(negedge clk) in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    restart  <= rs;
    do @(posedge clk); while (!in_ready);
    cells_due.push_back(spiral_next_cell(rs));
    requests_sent++;
  endtask

  // Holds off the sender until every outstanding result has been taken.
  task automatic wait_all_results();
    @(negedge clk) in_valid <= 1'b0;
    while (cells_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [DATA_W-1:0] val);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(negedge clk) penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      REG_ROW_COUNT:    grid_rows = val[CNT_W-1:0];
      REG_COLUMN_COUNT: grid_cols = val[CNT_W-1:0];
      REG_WALK_MODE:    grid_mode = val[MODE_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic set_grid(input int rows, input int cols, input logic [MODE_W-1:0] mode);
    wait_all_results();
    write_reg(REG_ROW_COUNT, rows);
    write_reg(REG_COLUMN_COUNT, cols);
    write_reg(REG_WALK_MODE, DATA_W'(mode));
  endtask

  task automatic run_walk(input int advances);
    send_request(1'b1);
    repeat (advances) send_request(1'b0);
  endtask

  task automatic test_idle_after_reset();
    send_request(1'b0);
    send_request(1'b0);
  endtask

  // The reset setting is a one by one grid, so the first cell is also the last.
  task automatic test_single_cell();
    send_request(1'b1);
    send_request(1'b0);
  endtask

  task automatic test_zero_size();
    set_grid(0, 0, MODE_CCW_UP);
    send_request(1'b1);
  endtask

  task automatic test_each_mode();
    set_grid(1, 3, MODE_CW_UP);
    run_walk(2);
    set_grid(3, 1, MODE_CCW_UP);
    run_walk(2);
    set_grid(2, 2, MODE_CCW_DOWN);
    run_walk(3);
    set_grid(2, 1, MODE_CW_DOWN);
    run_walk(1);
    send_request(1'b0);
  endtask

  task automatic test_restart_mid_walk();
    set_grid(2, 3, MODE_CW_UP);
    run_walk(1);
    send_request(1'b1);
  endtask

  // Oversized counts are clamped; a mode change during a walk waits for the next restart.
  task automatic test_late_config();
    idling_on = 1'b0;
    set_grid(31, 31, MODE_CW_DOWN);
    send_request(1'b1);
    wait_all_results();
    write_reg(REG_WALK_MODE, DATA_W'(MODE_CW_UP));
    send_request(1'b0);
    send_request(1'b1);
    idling_on = 1'b1;
  endtask

  task automatic test_random_walks();
    int first, rows, cols, cells, cut, extra, big;
    first = requests_sent;
    while (requests_sent - first < RANDOM_ITEMS) begin
      idling_on = ($urandom_range(0, 3) != 0);
      big = ($urandom_range(0, 11) == 0) && (requests_sent - first < 300);
      if (big) begin
        rows = $urandom_range(9, 31);
        cols = $urandom_range(9, 31);
      end else begin
        rows = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 6);
        cols = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 6);
      end
      set_grid(rows, cols, MODE_W'($urandom_range(0, 3)));
      cells = clamp_side(CNT_W'(rows)) * clamp_side(CNT_W'(cols));
      repeat (big ? 1 : $urandom_range(1, 3)) begin
        case ($urandom_range(0, 7))
          0: begin
            // Noise: arbitrary restart bits with no regard for the walk.
            repeat ($urandom_range(1, 5)) send_request(1'($urandom_range(0, 1)));
          end
          1: begin
            // Walk cut after a random number of cells, which may be the whole walk.
            cut = $urandom_range(1, cells);
            run_walk(cut - 1);
          end
          2: begin
            run_walk(cells / 2);
            wait_all_results();
            repeat (cells - 1 - cells / 2) send_request(1'b0);
          end
          default: begin
            extra = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 2) : 0;
            run_walk(cells - 1 + extra);
          end
        endcase
      end
    end
    idling_on = 1'b1;
  endtask

  initial begin
    rst      = 1'b1;
    in_valid = 1'b0;
    restart  = 1'b0;
    psel     = 1'b0;
    penable  = 1'b0;
    pwrite   = 1'b0;
    paddr    = '0;
    pwdata   = '0;
    grid_rows = 5'd1;
    grid_cols = 5'd1;
    grid_mode = MODE_CW_UP;
    top_b = 0;
    bot_b = 0;
    left_b = 0;
    right_b = 0;
    lane = 2'd0;
    lane_pos = 0;
    next_number = '0;
    walking = 1'b0;
    walk_ccw = 1'b0;
    walk_down = 1'b0;
    repeat (11) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    test_idle_after_reset();
    test_single_cell();
    test_zero_size();
    test_each_mode();
    test_restart_mid_walk();
    test_late_config();
    test_random_walks();

    wait_all_results();
    repeat (10) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
